>>> hdl/bta_pkg.sv
package bta_pkg;

   // default geometry
   localparam int REGION_BITS_DEF     = 21;
   localparam int GRANULE_BITS_DEF    = 3;
   localparam int REGION_SLOTS_DEF    = 8;
   localparam int NODE_POOL_DEPTH_DEF = 4096;

   // fixed port widths
   localparam int ADDR_W   = 24;
   localparam int SIZE_W   = 22;
   localparam int ACTIVE_W = 4;

   // free level field of a slab word
   localparam int LVL_W = 5;
   localparam logic [LVL_W-1:0] FULL_LEVEL = 5'd31;

   // csr register index (byte address bit 2)
   localparam logic CSR_IDX_ACTIVE = 1'b0;

   typedef enum logic [1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_FREE    = 2'd1,
      MODE_QUERY   = 2'd2,
      MODE_IGNORED = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ZERO_SIZE = 2'd1,
      ST_NO_MEMORY = 2'd2,
      ST_UNMANAGED = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_DESC,
      S_DESC_WAIT,
      S_SPLIT,
      S_SPLIT_WAIT,
      S_LEAF,
      S_UP,
      S_UP_WAIT,
      S_DONE
   } ctl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_START,
      OP_DESC_ISSUE,
      OP_DESC_TAKE,
      OP_SPLIT,
      OP_SPLIT_TAKE,
      OP_LEAF,
      OP_UP,
      OP_UP_TAKE,
      OP_QRESULT,
      OP_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic start_done;
      logic desc_more;
      logic split_go;
      logic split_new;
      logic depth_zero;
      logic up_root;
      logic out_free;
      logic is_alloc;
      logic is_query;
   } dp_stat_type;

endpackage

>>> hdl/bta_ctrl.sv
module bta_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bta_pkg::dp_stat_type  stat,
   output bta_pkg::dp_cmd_type   cmd
);

   bta_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bta_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bta_pkg::S_IDLE: begin
            if (req_valid) state_in = bta_pkg::S_START;
         end
         bta_pkg::S_START: begin
            state_in = stat.start_done ? bta_pkg::S_DONE : bta_pkg::S_DESC;
         end
         bta_pkg::S_DESC: begin
            priority if (stat.desc_more) state_in = bta_pkg::S_DESC_WAIT;
            else if (stat.is_query)      state_in = bta_pkg::S_DONE;
            else if (stat.is_alloc)      state_in = bta_pkg::S_SPLIT;
            else                         state_in = bta_pkg::S_LEAF;
         end
         bta_pkg::S_DESC_WAIT: state_in = bta_pkg::S_DESC;
         bta_pkg::S_SPLIT: begin
            priority if (!stat.split_go) state_in = bta_pkg::S_LEAF;
            else if (stat.split_new)     state_in = bta_pkg::S_SPLIT;
            else                         state_in = bta_pkg::S_SPLIT_WAIT;
         end
         bta_pkg::S_SPLIT_WAIT: state_in = bta_pkg::S_SPLIT;
         bta_pkg::S_LEAF: state_in = bta_pkg::S_UP;
         bta_pkg::S_UP: begin
            priority if (stat.depth_zero) state_in = bta_pkg::S_DONE;
            else if (stat.up_root)        state_in = bta_pkg::S_UP;
            else                          state_in = bta_pkg::S_UP_WAIT;
         end
         bta_pkg::S_UP_WAIT: state_in = bta_pkg::S_UP;
         bta_pkg::S_DONE: begin
            if (stat.out_free) state_in = bta_pkg::S_IDLE;
         end
         default: state_in = bta_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op    = bta_pkg::OP_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         bta_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.op = bta_pkg::OP_ACCEPT;
         end
         bta_pkg::S_START: cmd.op = bta_pkg::OP_START;
         bta_pkg::S_DESC: begin
            priority if (stat.desc_more) cmd.op = bta_pkg::OP_DESC_ISSUE;
            else if (stat.is_query)      cmd.op = bta_pkg::OP_QRESULT;
            else                         cmd.op = bta_pkg::OP_NONE;
         end
         bta_pkg::S_DESC_WAIT: cmd.op = bta_pkg::OP_DESC_TAKE;
         bta_pkg::S_SPLIT: begin
            if (stat.split_go) cmd.op = bta_pkg::OP_SPLIT;
         end
         bta_pkg::S_SPLIT_WAIT: cmd.op = bta_pkg::OP_SPLIT_TAKE;
         bta_pkg::S_LEAF:       cmd.op = bta_pkg::OP_LEAF;
         bta_pkg::S_UP:         cmd.op = bta_pkg::OP_UP;
         bta_pkg::S_UP_WAIT:    cmd.op = bta_pkg::OP_UP_TAKE;
         bta_pkg::S_DONE: begin
            if (stat.out_free) cmd.op = bta_pkg::OP_LOAD;
         end
         default: cmd.op = bta_pkg::OP_NONE;
      endcase
   end

endmodule

>>> hdl/bta_datapath.sv
module bta_datapath #(
   parameter int REGION_BITS     = bta_pkg::REGION_BITS_DEF,
   parameter int GRANULE_BITS    = bta_pkg::GRANULE_BITS_DEF,
   parameter int REGION_SLOTS    = bta_pkg::REGION_SLOTS_DEF,
   parameter int NODE_POOL_DEPTH = bta_pkg::NODE_POOL_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bta_pkg::dp_cmd_type           cmd,
   output bta_pkg::dp_stat_type          stat,
   input  logic [bta_pkg::ACTIVE_W-1:0]  active_regions,
   input  logic [1:0]                    req_mode,
   input  logic [bta_pkg::SIZE_W-1:0]    req_request_size,
   input  logic [bta_pkg::ADDR_W-1:0]    req_block_address,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [bta_pkg::ADDR_W-1:0]    rsp_result_address,
   output logic [bta_pkg::SIZE_W-1:0]    rsp_block_bytes,
   output logic                          rsp_fits
);

   localparam int PB     = REGION_BITS - GRANULE_BITS;
   localparam int DW     = $clog2(PB + 1);
   localparam int NW     = $clog2(NODE_POOL_DEPTH);
   localparam int UW     = NW + 1;
   localparam int RW     = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int LW     = bta_pkg::LVL_W;
   localparam int SW     = NW + LW + 2;
   localparam int PW     = 2 * SW;
   localparam int LV_LO  = NW;
   localparam int LV_HI  = NW + LW - 1;
   localparam int WAS_B  = NW + LW;
   localparam int IS_B   = NW + LW + 1;
   localparam int SUM_W  = DW + LW + 1;
   localparam int CMP_W  = (PB + 1 > bta_pkg::SIZE_W + 1) ? PB + 1 : bta_pkg::SIZE_W + 1;
   localparam int SH_W   = $clog2(REGION_BITS + 1);
   localparam int AX_W   = 1 << SH_W;
   localparam int WA_W   = REGION_BITS + RW;
   localparam int BY_W   = REGION_BITS + 1;
   localparam int AW     = bta_pkg::ADDR_W;
   localparam int ZW     = bta_pkg::SIZE_W;

   // true when a block at level x holds sg granules
   function automatic logic fit_g(input logic [SUM_W-1:0] x, input logic [CMP_W-1:0] sg);
      logic [CMP_W-1:0] b;
      logic             f;
      f = 1'b0;
      b = '0;
      if (x <= SUM_W'(PB)) begin
         b = CMP_W'(1) << (SUM_W'(PB) - x);
         f = (b >= sg);
      end
      return f;
   endfunction

   function automatic logic [LW-1:0] lvl_of(input logic [SW-1:0] s);
      return s[LV_HI:LV_LO];
   endfunction

   function automatic logic [PW-1:0] put_side(input logic [PW-1:0] p, input logic [SW-1:0] s,
                                              input logic side);
      logic [PW-1:0] q;
      q = p;
      if (side) q[PW-1:SW] = s;
      else      q[SW-1:0]  = s;
      return q;
   endfunction

   // refresh from the child pair, or merge buddies on free
   function automatic logic [SW-1:0] upd(input logic [SW-1:0] par, input logic [PW-1:0] pr,
                                         input logic merge);
      logic [SW-1:0] n;
      logic [LW-1:0] l;
      logic [LW-1:0] r;
      n = par;
      l = pr[LV_HI:LV_LO];
      r = pr[SW+LV_HI:SW+LV_LO];
      if (merge && l == '0 && r == '0) begin
         n[IS_B]        = 1'b0;
         n[WAS_B]       = 1'b1;
         n[LV_HI:LV_LO] = '0;
      end else if (l == bta_pkg::FULL_LEVEL && r == bta_pkg::FULL_LEVEL) begin
         n[LV_HI:LV_LO] = bta_pkg::FULL_LEVEL;
      end else begin
         n[LV_HI:LV_LO] = ((l <= r) ? l : r) + LW'(1);
      end
      return n;
   endfunction

   bta_pkg::mode_type    mode_ff;
   logic [ZW-1:0]        req_size_ff;
   logic [AW-1:0]        blk_addr_ff;
   logic [CMP_W-1:0]     size_g_ff;
   logic [RW-1:0]        region_ff;
   logic [DW-1:0]        depth_ff;
   logic [SW-1:0]        cur_ff;
   logic [PW-1:0]        cur_pair_ff;
   logic [PW-1:0]        child_ff;
   logic [NW-1:0]        cur_node_ff;
   logic                 cur_side_ff;
   logic [WA_W-1:0]      work_addr_ff;
   logic [NW-1:0]        path_node_ff [PB+1];
   logic                 path_side_ff [PB+1];
   logic [UW-1:0]        used_ff;
   logic [SW-1:0]        root_ff [REGION_SLOTS];
   logic [PW-1:0]        pool_mem [NODE_POOL_DEPTH];
   logic [PW-1:0]        rdata_ff;

   bta_pkg::status_type  res_status_ff;
   logic [AW-1:0]        res_addr_ff;
   logic [ZW-1:0]        res_bytes_ff;
   logic                 res_fits_ff;

   logic                 rsp_valid_ff;
   bta_pkg::status_type  rsp_status_ff;
   logic [AW-1:0]        rsp_addr_ff;
   logic [ZW-1:0]        rsp_bytes_ff;
   logic                 rsp_fits_ff;

   logic                 is_alloc, is_query, is_free;
   logic [DW-1:0]        dn;
   logic [DW-1:0]        dm;
   logic [NW-1:0]        cur_idx;
   logic [SUM_W-1:0]     sum_l, sum_r;
   logic                 ls_fit, rs_fit, ls_le_rs, side_alloc, side_loc, side;
   logic [AX_W-1:0]      addr_x;
   logic [SH_W-1:0]      sh_dn, sh_d;
   logic                 found;
   logic [RW-1:0]        found_r;
   logic [63:0]          a64;
   logic                 unmanaged;
   logic [RW-1:0]        start_r;
   logic                 start_done;
   bta_pkg::status_type  start_status;
   logic [BY_W-1:0]      bytes_w;
   logic [63:0]          bytes64;
   logic [63:0]          work64;
   logic [AW-1:0]        loc_addr;
   logic [AW-1:0]        res_addr_d;
   logic [SW-1:0]        split_cur;
   logic [NW-1:0]        split_n;
   logic [SW-1:0]        leaf_cur;
   logic [PW-1:0]        child_d;
   logic                 mem_we, mem_re;
   logic [NW-1:0]        mem_waddr, mem_raddr;
   logic [PW-1:0]        mem_wdata;

   assign is_alloc = (mode_ff == bta_pkg::MODE_ALLOC);
   assign is_query = (mode_ff == bta_pkg::MODE_QUERY);
   assign is_free  = (mode_ff == bta_pkg::MODE_FREE);
   assign dn       = depth_ff + DW'(1);
   assign dm       = depth_ff - DW'(1);
   assign cur_idx  = cur_ff[NW-1:0];

   // descent choice toward the tighter fitting child
   assign sum_l    = SUM_W'(rdata_ff[LV_HI:LV_LO]) + SUM_W'(dn);
   assign sum_r    = SUM_W'(rdata_ff[SW+LV_HI:SW+LV_LO]) + SUM_W'(dn);
   assign ls_fit   = fit_g(sum_l, size_g_ff);
   assign rs_fit   = fit_g(sum_r, size_g_ff);
   assign ls_le_rs = (sum_l > SUM_W'(REGION_BITS)) ||
                     ((sum_r <= SUM_W'(REGION_BITS)) && (sum_l >= sum_r));
   assign side_alloc = (!rs_fit || (ls_fit && ls_le_rs)) ? 1'b0 : 1'b1;
   assign addr_x   = AX_W'(blk_addr_ff);
   assign sh_dn    = SH_W'(REGION_BITS) - SH_W'(dn);
   assign sh_d     = SH_W'(REGION_BITS) - SH_W'(depth_ff);
   assign side_loc = addr_x[sh_dn];
   assign side     = is_alloc ? side_alloc : side_loc;

   // first active region whose root can hold the request
   always_comb begin
      found   = 1'b0;
      found_r = '0;
      for (int r = REGION_SLOTS - 1; r >= 0; r--) begin
         if ((5'(r) < {1'b0, active_regions}) &&
             fit_g(SUM_W'(lvl_of(root_ff[r])), size_g_ff)) begin
            found   = 1'b1;
            found_r = RW'(r);
         end
      end
   end

   assign a64       = 64'(blk_addr_ff) >> REGION_BITS;
   assign unmanaged = (a64 >= 64'(REGION_SLOTS));
   assign start_r   = is_alloc ? found_r : a64[RW-1:0];

   always_comb begin
      start_done   = 1'b0;
      start_status = bta_pkg::ST_OK;
      unique case (mode_ff)
         bta_pkg::MODE_ALLOC: begin
            if (req_size_ff == '0) begin
               start_done   = 1'b1;
               start_status = bta_pkg::ST_ZERO_SIZE;
            end else if (!found) begin
               start_done   = 1'b1;
               start_status = bta_pkg::ST_NO_MEMORY;
            end
         end
         bta_pkg::MODE_FREE, bta_pkg::MODE_QUERY: begin
            if (unmanaged) begin
               start_done   = 1'b1;
               start_status = bta_pkg::ST_UNMANAGED;
            end
         end
         bta_pkg::MODE_IGNORED: start_done = 1'b1;
         default: start_done = 1'b1;
      endcase
   end

   // block size and start for the current depth
   assign bytes_w = BY_W'(1) << sh_d;
   assign bytes64 = 64'(bytes_w);
   assign work64  = 64'(work_addr_ff);
   always_comb begin
      for (int i = 0; i < AW; i++) begin
         loc_addr[i] = blk_addr_ff[i] & (i >= int'(sh_d));
      end
   end
   assign res_addr_d = is_alloc ? work64[AW-1:0] : loc_addr;

   // split of the current slab
   assign split_n = cur_ff[WAS_B] ? cur_idx : used_ff[NW-1:0];
   always_comb begin
      split_cur              = cur_ff;
      split_cur[IS_B]        = 1'b1;
      split_cur[LV_HI:LV_LO] = LW'(1);
      split_cur[NW-1:0]      = split_n;
   end

   always_comb begin
      leaf_cur              = cur_ff;
      leaf_cur[LV_HI:LV_LO] = is_alloc ? bta_pkg::FULL_LEVEL : LW'(0);
   end

   assign child_d = put_side(cur_pair_ff, cur_ff, cur_side_ff);

   // node memory ports
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = cur_node_ff;
      mem_raddr = cur_idx;
      mem_wdata = child_d;
      unique case (cmd.op)
         bta_pkg::OP_DESC_ISSUE: mem_re = 1'b1;
         bta_pkg::OP_SPLIT: begin
            mem_we    = (depth_ff != '0);
            mem_wdata = put_side(cur_pair_ff, split_cur, cur_side_ff);
            mem_re    = cur_ff[WAS_B];
         end
         bta_pkg::OP_UP: begin
            mem_we    = (depth_ff != '0);
            mem_re    = (depth_ff > DW'(1));
            mem_raddr = path_node_ff[dm];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) pool_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= pool_mem[mem_raddr];
   end

   // working registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         bta_pkg::OP_ACCEPT: begin
            mode_ff     <= bta_pkg::mode_type'(req_mode);
            req_size_ff <= req_request_size;
            blk_addr_ff <= req_block_address;
            size_g_ff   <= CMP_W'((req_request_size - ZW'(1)) >> GRANULE_BITS) + CMP_W'(1);
         end
         bta_pkg::OP_START: begin
            region_ff     <= start_r;
            cur_ff        <= root_ff[start_r];
            depth_ff      <= '0;
            work_addr_ff  <= WA_W'(start_r) << REGION_BITS;
            res_status_ff <= start_status;
            res_addr_ff   <= '0;
            res_bytes_ff  <= '0;
            res_fits_ff   <= 1'b0;
         end
         bta_pkg::OP_DESC_TAKE: begin
            depth_ff          <= dn;
            cur_pair_ff       <= rdata_ff;
            cur_ff            <= side ? rdata_ff[PW-1:SW] : rdata_ff[SW-1:0];
            cur_node_ff       <= cur_idx;
            cur_side_ff       <= side;
            path_node_ff[dn]  <= cur_idx;
            path_side_ff[dn]  <= side;
            if (is_alloc && side) begin
               work_addr_ff <= work_addr_ff | (WA_W'(1) << sh_dn);
            end
         end
         bta_pkg::OP_SPLIT: begin
            depth_ff         <= dn;
            cur_node_ff      <= split_n;
            cur_side_ff      <= 1'b0;
            path_node_ff[dn] <= split_n;
            path_side_ff[dn] <= 1'b0;
            if (!cur_ff[WAS_B]) begin
               cur_pair_ff <= '0;
               cur_ff      <= '0;
            end
         end
         bta_pkg::OP_SPLIT_TAKE: begin
            cur_pair_ff <= rdata_ff;
            cur_ff      <= rdata_ff[SW-1:0];
         end
         bta_pkg::OP_LEAF: begin
            cur_ff        <= leaf_cur;
            res_status_ff <= bta_pkg::ST_OK;
            res_addr_ff   <= res_addr_d;
            res_bytes_ff  <= bytes64[ZW-1:0];
            res_fits_ff   <= 1'b0;
         end
         bta_pkg::OP_QRESULT: begin
            res_status_ff <= bta_pkg::ST_OK;
            res_addr_ff   <= res_addr_d;
            res_bytes_ff  <= bytes64[ZW-1:0];
            res_fits_ff   <= (64'(req_size_ff) <= bytes64);
         end
         bta_pkg::OP_UP: begin
            if (depth_ff != '0) begin
               child_ff <= child_d;
               depth_ff <= dm;
               if (dm == '0) begin
                  cur_ff <= upd(root_ff[region_ff], child_d, is_free);
               end
            end
         end
         bta_pkg::OP_UP_TAKE: begin
            cur_ff      <= upd(path_side_ff[depth_ff] ? rdata_ff[PW-1:SW] : rdata_ff[SW-1:0],
                               child_ff, is_free);
            cur_pair_ff <= rdata_ff;
            cur_node_ff <= path_node_ff[depth_ff];
            cur_side_ff <= path_side_ff[depth_ff];
         end
         default: ;
      endcase
   end

   // root slabs and pool fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         for (int r = 0; r < REGION_SLOTS; r++) begin
            root_ff[r] <= '0;
         end
      end else begin
         if (cmd.op == bta_pkg::OP_SPLIT) begin
            if (!cur_ff[WAS_B]) used_ff <= used_ff + UW'(1);
            if (depth_ff == '0) root_ff[region_ff] <= split_cur;
         end
         if (cmd.op == bta_pkg::OP_UP && depth_ff == '0) begin
            root_ff[region_ff] <= cur_ff;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == bta_pkg::OP_LOAD) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == bta_pkg::OP_LOAD) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_bytes_ff  <= res_bytes_ff;
         rsp_fits_ff   <= res_fits_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_block_bytes    = rsp_bytes_ff;
   assign rsp_fits           = rsp_fits_ff;

   assign stat.start_done = start_done;
   assign stat.desc_more  = cur_ff[IS_B] && (depth_ff < DW'(PB));
   assign stat.split_go   = (depth_ff < DW'(PB)) && fit_g(SUM_W'(dn), size_g_ff) &&
                            (cur_ff[WAS_B] || (used_ff < UW'(NODE_POOL_DEPTH)));
   assign stat.split_new  = !cur_ff[WAS_B];
   assign stat.depth_zero = (depth_ff == '0);
   assign stat.up_root    = (depth_ff == DW'(1));
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;
   assign stat.is_alloc   = is_alloc;
   assign stat.is_query   = is_query;

endmodule

>>> hdl/buddy_tree_allocator.sv
// buddy allocator over up to REGION_SLOTS regions of 2^REGION_BITS bytes, granule 2^GRANULE_BITS.
// one request at a time: allocate (mode 0), free (mode 1) or query block size (mode 2); each
// request gives exactly one response. the tree lives in a node memory of NODE_POOL_DEPTH slab
// pairs with one read and one write port. a level walked down issues a read and then uses the
// data, a split on a reused pair reads that pair back while a fresh pair needs no read, and a
// level walked back up writes the child pair and reads its parent, with no read for the last
// two levels. errors and mode 3 end without a walk, a query ends after its walk down, a free
// walks down and back up merging buddies, and an allocation walks down, splits toward the
// requested size and walks back up. a response held in the output register under stall holds
// back the load of the next one. the input is stalled while a request is in flight; a finished
// response sits in an output register, so the next request is taken while it waits.
// active_regions is written at csr byte address 0.
module buddy_tree_allocator #(
   parameter int REGION_BITS     = bta_pkg::REGION_BITS_DEF,
   parameter int GRANULE_BITS    = bta_pkg::GRANULE_BITS_DEF,
   parameter int REGION_SLOTS    = bta_pkg::REGION_SLOTS_DEF,
   parameter int NODE_POOL_DEPTH = bta_pkg::NODE_POOL_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_mode,
   input  logic [bta_pkg::SIZE_W-1:0]    req_request_size,
   input  logic [bta_pkg::ADDR_W-1:0]    req_block_address,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [bta_pkg::ADDR_W-1:0]    rsp_result_address,
   output logic [bta_pkg::SIZE_W-1:0]    rsp_block_bytes,
   output logic                          rsp_fits,
   // csr port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   logic [bta_pkg::ACTIVE_W-1:0] active_regions_ff;
   logic                         csr_wr;
   bta_pkg::dp_cmd_type          cmd;
   bta_pkg::dp_stat_type         stat;

   // csr: single register, always ready
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == bta_pkg::CSR_IDX_ACTIVE);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_regions_ff <= bta_pkg::ACTIVE_W'(1);
      end else if (csr_wr) begin
         active_regions_ff <= csr_pwdata[bta_pkg::ACTIVE_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == bta_pkg::CSR_IDX_ACTIVE) ? 32'(active_regions_ff) : '0;

   // sequencer
   bta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // tree walk datapath with node memory
   bta_datapath #(
      .REGION_BITS     (REGION_BITS),
      .GRANULE_BITS    (GRANULE_BITS),
      .REGION_SLOTS    (REGION_SLOTS),
      .NODE_POOL_DEPTH (NODE_POOL_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .active_regions     (active_regions_ff),
      .req_mode           (req_mode),
      .req_request_size   (req_request_size),
      .req_block_address  (req_block_address),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_result_address (rsp_result_address),
      .rsp_block_bytes    (rsp_block_bytes),
      .rsp_fits           (rsp_fits)
   );

`ifndef SYNTHESIS
   // an accepted request keeps the input stalled while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // a response is only loaded when the output register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.op == bta_pkg::OP_LOAD |-> (!rsp_valid || !rsp_stall))
      else $error("pending response overwritten");

   // splitting only happens when the sequencer saw room to split
   a_split_allowed: assert property (@(posedge clock) disable iff (reset)
      cmd.op == bta_pkg::OP_SPLIT |-> stat.split_go && stat.is_alloc)
      else $error("split issued without room");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int LIMIT_CYCLES = 2000000;
   localparam int DRAIN_CYCLES = 120;
   localparam int PATH_LEN = 18;
   localparam int POOL_N = 4096;

   typedef struct {
      bta_pkg::status_type status;
      logic [23:0]         addr;
      logic [21:0]         bytes;
      logic                fits;
   } resp_type;

   typedef struct {
      bta_pkg::mode_type mode;
      logic [21:0]       size;
      logic [23:0]       addr;
      resp_type          want;
   } request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = 2'd0;
   logic [21:0] req_request_size = '0;
   logic [23:0] req_block_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [23:0] rsp_result_address;
   logic [21:0] rsp_block_bytes;
   logic        rsp_fits;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   buddy_tree_allocator dut (.*);

   // shadow allocator state
   logic [31:0] root_word [8];
   logic [31:0] pool_word [POOL_N][2];
   int unsigned pairs_taken;
   int unsigned trail [PATH_LEN+1];
   logic [3:0]  regions_cfg;

   request_type pending_reqs[$];
   resp_type    awaited_resps[$];
   logic [23:0] live_blocks[$];
   int          fail_count = 0;
   int          cycle_count = 0;
   bit          calm = 1'b0;
   int          send_gap = 0;
   int          hold_gap = 0;

   function automatic longint unsigned span(int unsigned s);
      return s >= 64 ? 0 : ((64'd1 << 21) >> s);
   endfunction

   function automatic int unsigned level_of(logic [31:0] w);
      return w[22:18];
   endfunction

   function automatic logic [31:0] with_level(logic [31:0] w, int unsigned v);
      w[22:18] = v[4:0];
      return w;
   endfunction

   function automatic int unsigned pair_of(logic [31:0] w);
      return w[17:0] % POOL_N;
   endfunction

   function automatic logic [31:0] slab_rd(int unsigned h);
      if (h < 8) return root_word[h];
      return pool_word[((h-8) >> 1) % POOL_N][(h-8) & 1];
   endfunction

   function automatic void slab_wr(int unsigned h, logic [31:0] w);
      if (h < 8) root_word[h] = w;
      else pool_word[((h-8) >> 1) % POOL_N][(h-8) & 1] = w;
   endfunction

   function automatic void recompute_level(int unsigned h);
      logic [31:0] w;
      int unsigned n, l, r;
      w = slab_rd(h);
      n = pair_of(w);
      l = level_of(pool_word[n][0]);
      r = level_of(pool_word[n][1]);
      if (l == 31 && r == 31) w = with_level(w, 31);
      else w = with_level(w, (l <= r ? l : r) + 1);
      slab_wr(h, w);
   endfunction

   function automatic resp_type predict_alloc(logic [21:0] req);
      resp_type r;
      int unsigned lim, reg_i, depth, n, d, side, h;
      longint unsigned need, offset, ls, rs;
      logic [31:0] w;
      r = '{bta_pkg::ST_OK, '0, '0, 1'b0};
      offset = 0;
      depth = 0;
      if (req == 0) begin
         r.status = bta_pkg::ST_ZERO_SIZE;
         return r;
      end
      need = (((longint'(req) - 1) >> 3) + 1) << 3;
      lim = regions_cfg > 8 ? 8 : regions_cfg;
      for (reg_i = 0; reg_i < lim; reg_i++)
         if (span(level_of(root_word[reg_i])) >= need) break;
      if (reg_i >= lim) begin
         r.status = bta_pkg::ST_NO_MEMORY;
         return r;
      end
      // walk down toward the tighter fit
      h = reg_i;
      trail[0] = h;
      w = slab_rd(h);
      while (w[24] && depth < PATH_LEN) begin
         n = pair_of(w);
         depth++;
         ls = span(level_of(pool_word[n][0]) + depth);
         rs = span(level_of(pool_word[n][1]) + depth);
         side = (rs < need || (ls >= need && ls <= rs)) ? 0 : 1;
         if (side) offset |= span(depth);
         h = 8 + 2*n + side;
         trail[depth] = h;
         w = slab_rd(h);
      end
      // split down to the requested size while pairs remain
      while (depth < PATH_LEN && span(depth + 1) >= need) begin
         n = pair_of(w);
         if (!w[23]) begin
            if (pairs_taken >= POOL_N) break;
            n = pairs_taken;
            pairs_taken++;
            pool_word[n][0] = '0;
            pool_word[n][1] = '0;
            w[17:0] = 18'(n);
         end
         w[24] = 1'b1;
         w = with_level(w, 1);
         slab_wr(h, w);
         depth++;
         h = 8 + 2*n;
         trail[depth] = h;
         w = slab_rd(h);
      end
      slab_wr(h, with_level(w, 31));
      for (d = depth; d > 0; ) begin
         d--;
         recompute_level(trail[d]);
      end
      r.addr = 24'((longint'(reg_i) << 21) + offset);
      r.bytes = 22'(span(depth));
      return r;
   endfunction

   function automatic resp_type predict_request(bta_pkg::mode_type m, logic [21:0] req,
                                                logic [23:0] a);
      resp_type r;
      int unsigned depth, n, d, sh, h;
      longint unsigned bytes;
      logic [31:0] w;
      r = '{bta_pkg::ST_OK, '0, '0, 1'b0};
      depth = 0;
      if (m == bta_pkg::MODE_ALLOC) return predict_alloc(req);
      if (m == bta_pkg::MODE_IGNORED) return r;
      if ((a >> 21) >= 8) begin
         r.status = bta_pkg::ST_UNMANAGED;
         return r;
      end
      // follow the address down to its block
      h = a >> 21;
      trail[0] = h;
      w = slab_rd(h);
      while (w[24] && depth < PATH_LEN) begin
         n = pair_of(w);
         depth++;
         h = 8 + 2*n + ((a >> (21 - depth)) & 1);
         trail[depth] = h;
         w = slab_rd(h);
      end
      bytes = span(depth);
      sh = 21 - depth;
      if (m == bta_pkg::MODE_FREE) begin
         slab_wr(trail[depth], with_level(slab_rd(trail[depth]), 0));
         // merge free buddies on the way up
         for (d = depth; d > 0; ) begin
            d--;
            w = slab_rd(trail[d]);
            n = pair_of(w);
            if (level_of(pool_word[n][0]) == 0 && level_of(pool_word[n][1]) == 0) begin
               w[24] = 1'b0;
               w[23] = 1'b1;
               slab_wr(trail[d], with_level(w, 0));
            end else begin
               recompute_level(trail[d]);
            end
         end
      end else begin
         r.fits = longint'(req) <= bytes;
      end
      r.addr = 24'((longint'(a) >> sh) << sh);
      r.bytes = 22'(bytes);
      return r;
   endfunction

   // clock and run limit
   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // request driver: bursts of idle, otherwise next pending request
   always @(posedge clock) begin
      request_type sent_q;
      if (!reset && (!req_valid || !req_stall)) begin
         if (req_valid) begin
            sent_q = pending_reqs.pop_front();
            awaited_resps.push_back(sent_q.want);
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 18);
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_valid <= 1'b1;
            req_mode <= pending_reqs[0].mode;
            req_request_size <= pending_reqs[0].size;
            req_block_address <= pending_reqs[0].addr;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor with random backpressure
   always @(posedge clock) begin
      resp_type exp_r;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_resps.size() == 0) begin
               $display("%0t: response with none expected, actual status %0d addr %h",
                        $time, rsp_status, rsp_result_address);
               fail_count++;
            end else begin
               exp_r = awaited_resps.pop_front();
               if (rsp_status !== exp_r.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                           rsp_status);
                  fail_count++;
               end
               if (rsp_result_address !== exp_r.addr) begin
                  $display("%0t: address expected %h actual %h", $time, exp_r.addr,
                           rsp_result_address);
                  fail_count++;
               end
               if (rsp_block_bytes !== exp_r.bytes) begin
                  $display("%0t: bytes expected %0d actual %0d", $time, exp_r.bytes,
                           rsp_block_bytes);
                  fail_count++;
               end
               if (rsp_fits !== exp_r.fits) begin
                  $display("%0t: fits expected %0d actual %0d", $time, exp_r.fits, rsp_fits);
                  fail_count++;
               end
            end
         end
         if (hold_gap > 0) begin
            hold_gap <= hold_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            hold_gap <= $urandom_range(0, 18);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // queue one request, predicting its response now since the block works in order
   task automatic add_request(bta_pkg::mode_type m, logic [21:0] sz, logic [23:0] a);
      request_type q;
      q.mode = m;
      q.size = sz;
      q.addr = a;
      q.want = predict_request(m, sz, a);
      if (m == bta_pkg::MODE_ALLOC && q.want.status == bta_pkg::ST_OK)
         live_blocks.push_back(q.want.addr);
      pending_reqs.push_back(q);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || awaited_resps.size() != 0 || req_valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'({bta_pkg::CSR_IDX_ACTIVE, 2'b00});
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      regions_cfg = v[3:0];
   endtask

   function automatic logic [21:0] pick_size();
      case ($urandom_range(0, 19))
         0: return '0;
         1, 2, 3, 4, 5, 6, 7, 8, 9: return $urandom_range(1, 64);
         10, 11, 12, 13, 14: return $urandom_range(1, 4096);
         15, 16: return $urandom_range(1, 65536);
         17: return 22'(1) << $urandom_range(3, 21);
         default: return $urandom_range(1, 2097152);
      endcase
   endfunction

   task automatic random_requests(int count);
      int unsigned k, sel;
      logic [23:0] a;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 45 || (sel < 75 && live_blocks.size() == 0)) begin
            add_request(bta_pkg::MODE_ALLOC, pick_size(), $urandom);
         end else if (sel < 75) begin
            // free a live block, sometimes through an inner address
            k = $urandom_range(0, live_blocks.size() - 1);
            a = live_blocks[k] + $urandom_range(0, 7);
            live_blocks.delete(k);
            add_request(bta_pkg::MODE_FREE, $urandom, a);
         end else if (sel < 90) begin
            a = live_blocks.size() ? live_blocks[$urandom_range(0, live_blocks.size() - 1)]
                                   : 24'($urandom);
            add_request(bta_pkg::MODE_QUERY, pick_size(), a + $urandom_range(0, 7));
         end else if (sel < 96) begin
            add_request(sel[0] ? bta_pkg::MODE_QUERY : bta_pkg::MODE_FREE,
                        $urandom_range(0, 2097152), 24'($urandom));
         end else begin
            add_request(bta_pkg::MODE_IGNORED, $urandom_range(0, 2097152), 24'($urandom));
         end
      end
      wait_idle();
   endtask

   initial begin
      foreach (root_word[i]) root_word[i] = '0;
      foreach (pool_word[i, j]) pool_word[i][j] = '0;
      pairs_taken = 0;
      regions_cfg = 4'd1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);

      // directed: size extremes, rounding, double free, ignored mode, top address
      add_request(bta_pkg::MODE_ALLOC, 22'd0, 24'd0);
      add_request(bta_pkg::MODE_ALLOC, 22'd1, 24'd0);
      add_request(bta_pkg::MODE_ALLOC, 22'd8, 24'd0);
      add_request(bta_pkg::MODE_ALLOC, 22'd9, 24'd0);
      add_request(bta_pkg::MODE_ALLOC, 22'd2097152, 24'd0);
      add_request(bta_pkg::MODE_QUERY, 22'd0, 24'd0);
      add_request(bta_pkg::MODE_QUERY, 22'h3FFFFF, 24'd9);
      add_request(bta_pkg::MODE_QUERY, 22'd2097152, 24'hFFFFFF);
      add_request(bta_pkg::MODE_FREE, 22'd0, 24'd0);
      add_request(bta_pkg::MODE_FREE, 22'd0, 24'd0);
      add_request(bta_pkg::MODE_FREE, 22'd0, 24'hFFFFFF);
      add_request(bta_pkg::MODE_IGNORED, 22'h3FFFFF, 24'hFFFFFF);
      add_request(bta_pkg::MODE_FREE, 22'd0, 24'd8);
      add_request(bta_pkg::MODE_FREE, 22'd0, 24'd16);
      add_request(bta_pkg::MODE_ALLOC, 22'd2097152, 24'd0);
      add_request(bta_pkg::MODE_ALLOC, 22'd2097151, 24'd0);
      add_request(bta_pkg::MODE_FREE, 22'd0, 24'd0);
      add_request(bta_pkg::MODE_ALLOC, 22'd2097151, 24'd0);
      live_blocks.delete();
      add_request(bta_pkg::MODE_FREE, 22'd0, 24'd0);
      wait_idle();

      // sweep region counts, including zero and above the slot count
      csr_write(32'd8);
      random_requests(450);
      csr_write(32'd0);
      random_requests(40);
      csr_write(32'd15);
      random_requests(300);
      csr_write(32'd3);
      random_requests(250);
      csr_write(32'd1);
      random_requests(60);

      // closing stretch with no idling on either side
      calm = 1'b1;
      csr_write(32'd8);
      random_requests(150);

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/bta_pkg.sv
hdl/bta_ctrl.sv
hdl/bta_datapath.sv
hdl/buddy_tree_allocator.sv
tb/tb.sv
